@@ rtl/rmv_pkg.sv @@
// Shared types and constants for the running mean and variance block.
`default_nettype none
package rmv_pkg;
  localparam int unsigned ValW = 56;
  localparam int unsigned SqW  = 64;
  localparam int unsigned CntW = 32;
  localparam int unsigned CiW  = 32;
  localparam logic [CiW-1:0] CiFail = 32'd4194304000;
  localparam logic [17:0] K196 = 18'd128451;
  localparam logic [31:0] CiThresholdReset = 32'd41943;
  localparam logic [1:0]  AddrThreshold = 2'd0;

  typedef enum logic [0:0] {
    ActAdd   = 1'b0,
    ActClear = 1'b1
  } action_t;

  // Request to the shared divider: quotient = floor(num / den).
  typedef struct packed {
    logic          start;
    logic [127:0]  num;
    logic [63:0]   den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [127:0]  quot;
  } div_rsp_t;
endpackage
`default_nettype wire

@@ rtl/running_mean_variance_ci.sv @@
// An added sample runs two 128-step divisions (x, then the mean step), the
// second deviation, four 32x32 partial products and the m2 accumulation.
// A CHECK_PERIOD-th sample, once the count is at least two and the mean is
// nonzero, also runs two more divisions for the variance, a 64-step square
// root and a division by the mean. A clear has its result ready in the cycle
// after it is accepted. One shared serial divider and one serial square-root
// unit do these steps. The block takes a new word only when the previous
// result has left its output register.
`default_nettype none
module running_mean_variance_ci #(
  parameter int unsigned MAX_ITERS    = 1048576,
  parameter int unsigned CHECK_PERIOD = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [1:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [47:0] sample_ns, [68:48] iteration_count, [71:69] zero
  input  wire logic [71:0]  s_tdata,
  // [0] action
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [31:0] ci_value, [63:32] sample_count, [119:64] mean_value,
  // [175:120] min_value, [231:176] max_value
  output logic [231:0]      m_tdata,
  // [0] converged
  output logic              m_tuser
);
  import rmv_pkg::*;

  localparam int unsigned PerW = (CHECK_PERIOD > 1) ? $clog2(CHECK_PERIOD) : 1;

  typedef enum logic [11:0] {
    StIdle  = 12'b000000000001,
    StDivX  = 12'b000000000010,
    StMean  = 12'b000000000100,
    StDivM  = 12'b000000001000,
    StD2    = 12'b000000010000,
    StMul   = 12'b000000100000,
    StAcc   = 12'b000001000000,
    StDivS1 = 12'b000010000000,
    StDivS2 = 12'b000100000000,
    StSqrt  = 12'b001000000000,
    StDivC  = 12'b010000000000,
    StOut   = 12'b100000000000
  } state_t;

  state_t state;
  logic [31:0] ci_threshold;
  logic [CntW-1:0] count;
  logic [ValW-1:0] mean, minimum, maximum, x;
  logic [SqW-1:0]  sq_dev_sum, d1, d2;
  logic [PerW-1:0] phase;
  logic            x_ge;
  logic [1:0]      mul_step;
  logic [127:0]    prod;
  logic [47:0]     sample;
  logic [20:0]     iters;
  div_req_t        dreq;
  div_rsp_t        drsp;
  logic            sq_start, sq_done;
  logic [63:0]     sd;
  logic [63:0]     s_val;
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     mul_p;
  logic [64:0]     acc_sum;
  logic [63:0]     term;
  logic [81:0]     num196;
  logic            check_now;

  rmv_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
  rmv_sqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start), .radicand_hi(s_val),
    .done(sq_done), .root(sd));

  assign pready = 1'b1;
  assign prdata = ci_threshold;
  assign s_tready = (state == StIdle) && !m_tvalid;

  always_ff @(posedge clk) begin
    if (rst) ci_threshold <= CiThresholdReset;
    else if (psel && penable && pwrite && paddr == AddrThreshold) ci_threshold <= pwdata;
  end

  // Zero iterations count as one; counts above the limit are clamped.
  assign sample = s_tdata[47:0];
  always_comb begin
    iters = s_tdata[68:48];
    if (iters == '0) iters = 21'd1;
    if ({11'd0, iters} > MAX_ITERS) iters = 21'(MAX_ITERS);
  end

  // 64x64 product done as four 32x32 partial products, one per cycle.
  always_comb begin
    unique case (mul_step)
      2'd0: begin mul_a = d1[31:0];  mul_b = d2[31:0];  end
      2'd1: begin mul_a = d1[63:32]; mul_b = d2[31:0];  end
      2'd2: begin mul_a = d1[31:0];  mul_b = d2[63:32]; end
      default: begin mul_a = d1[63:32]; mul_b = d2[63:32]; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign term = (prod[127:80] != '0) ? '1 : prod[79:16];
  assign acc_sum = {1'b0, sq_dev_sum} + {1'b0, term};
  assign num196 = sd * K196;
  // phase follows count modulo CHECK_PERIOD, so zero marks a check.
  assign check_now = (phase == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      m_tvalid <= 1'b0;
      count <= '0;
      mean <= '0;
      sq_dev_sum <= '0;
      minimum <= '1;
      maximum <= '0;
      phase <= '0;
      dreq.start <= 1'b0;
      sq_start <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      sq_start <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        StIdle: begin
          if (s_tvalid && s_tready) begin
            if (action_t'(s_tuser) == ActClear) begin
              count <= '0; mean <= '0; sq_dev_sum <= '0;
              minimum <= '1; maximum <= '0; phase <= '0;
              m_tuser <= 1'b0;
              m_tdata <= {56'd0, {ValW{1'b1}}, 56'd0, 32'd0, CiFail};
              m_tvalid <= 1'b1;
            end else begin
              dreq.num <= {64'd0, sample, 16'd0};
              dreq.den <= {43'd0, iters};
              dreq.start <= 1'b1;
              // A saturated count no longer advances the check phase.
              if (count != '1) begin
                count <= count + 32'd1;
                phase <= (phase == PerW'(CHECK_PERIOD - 1)) ? '0 : phase + PerW'(1);
              end
              state <= StDivX;
            end
          end
        end
        StDivX: if (drsp.done) begin
          x <= (drsp.quot[127:56] != '0) ? '1 : drsp.quot[55:0];
          state <= StMean;
        end
        StMean: begin
          x_ge <= x >= mean;
          d1 <= (x >= mean) ? {8'd0, x - mean} : {8'd0, mean - x};
          dreq.num <= (x >= mean) ? {72'd0, x - mean} : {72'd0, mean - x};
          dreq.den <= {32'd0, count};
          dreq.start <= 1'b1;
          if (x < minimum) minimum <= x;
          if (x > maximum) maximum <= x;
          state <= StDivM;
        end
        StDivM: if (drsp.done) begin
          mean <= x_ge ? mean + drsp.quot[55:0] : mean - drsp.quot[55:0];
          state <= StD2;
        end
        StD2: begin
          d2 <= x_ge ? {8'd0, x - mean} : {8'd0, mean - x};
          mul_step <= 2'd0;
          prod <= '0;
          state <= StMul;
        end
        StMul: begin
          unique case (mul_step)
            2'd0: prod <= prod + {64'd0, mul_p};
            2'd1, 2'd2: prod <= prod + {32'd0, mul_p, 32'd0};
            default: prod <= prod + {mul_p, 64'd0};
          endcase
          mul_step <= mul_step + 2'd1;
          if (mul_step == 2'd3) state <= StAcc;
        end
        StAcc: begin
          sq_dev_sum <= acc_sum[64] ? '1 : acc_sum[63:0];
          m_tuser <= 1'b0;
          m_tdata <= {maximum, minimum, mean, count, CiFail};
          if (check_now && count >= 32'd2 && mean != '0) begin
            dreq.num <= {64'd0, acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0]};
            dreq.den <= {32'd0, count - 32'd1};
            dreq.start <= 1'b1;
            state <= StDivS1;
          end else begin
            m_tvalid <= 1'b1;
            state <= StIdle;
          end
        end
        StDivS1: if (drsp.done) begin
          dreq.num <= drsp.quot;
          dreq.den <= {32'd0, count};
          dreq.start <= 1'b1;
          state <= StDivS2;
        end
        StDivS2: if (drsp.done) begin
          s_val <= drsp.quot[63:0];
          sq_start <= 1'b1;
          state <= StSqrt;
        end
        StSqrt: if (sq_done) begin
          state <= StOut;
        end
        StOut: begin
          dreq.num <= {64'd0, num196[81:18]};
          dreq.den <= {8'd0, mean};
          dreq.start <= 1'b1;
          state <= StDivC;
        end
        StDivC: if (drsp.done) begin
          if (drsp.quot[127:32] == '0 && drsp.quot[31:0] < ci_threshold) begin
            m_tuser <= 1'b1;
            m_tdata[31:0] <= drsp.quot[31:0];
          end else if (drsp.quot[127:32] != '0 && 32'hFFFF_FFFF < ci_threshold) begin
            m_tuser <= 1'b1;
            m_tdata[31:0] <= 32'hFFFF_FFFF;
          end
          m_tvalid <= 1'b1;
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

  property p_no_accept_busy;
    @(posedge clk) disable iff (rst) (state != StIdle) |-> !s_tready;
  endproperty
  assert property (p_no_accept_busy) else $error("input taken while busy");

  property p_result_holds;
    @(posedge clk) disable iff (rst) (m_tvalid && !m_tready) |=> m_tvalid;
  endproperty
  assert property (p_result_holds) else $error("result dropped");

  property p_min_max;
    @(posedge clk) disable iff (rst) (count != '0 && state == StIdle) |-> minimum <= maximum;
  endproperty
  assert property (p_min_max) else $error("minimum above maximum");
endmodule
`default_nettype wire

@@ rtl/rmv_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle, shared by all divides.
`default_nettype none
module rmv_div (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rmv_pkg::div_req_t req,
  output rmv_pkg::div_rsp_t    rsp
);
  import rmv_pkg::*;

  logic         busy;
  logic         done;
  logic [6:0]   step;
  logic [127:0] quot;
  logic [64:0]  rem;
  logic [63:0]  den;
  logic [64:0]  trial;
  logic         fit;

  assign trial = {rem[63:0], quot[127]};
  assign fit   = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 7'd1;
        if (step == 7'd127) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.num;
      rem  <= '0;
      den  <= req.den;
    end else if (busy) begin
      rem  <= fit ? trial - {1'b0, den} : trial;
      quot <= {quot[126:0], fit};
    end
  end

  assign rsp = {done, quot};
endmodule
`default_nettype wire

@@ rtl/rmv_sqrt.sv @@
// Bit-serial integer square root of a 128-bit radicand, one result bit a cycle.
`default_nettype none
module rmv_sqrt (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [63:0]   radicand_hi,
  output logic               done,
  output logic [63:0]        root
);
  logic         busy;
  logic [5:0]   step;
  logic [127:0] rad;
  logic [65:0]  rem;
  logic [65:0]  trial;
  logic [65:0]  sub;
  logic         fit;

  assign trial = {rem[63:0], rad[127:126]};
  assign sub   = {root, 2'b01};
  assign fit   = trial >= sub;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 6'd1;
        if (step == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= {radicand_hi, 64'd0};
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[125:0], 2'b00};
      rem  <= fit ? trial - sub : trial;
      root <= {root[62:0], fit};
    end
  end
endmodule
`default_nettype wire
